@@ hdl/arcp_pkg.sv @@
// ============================================================================
// arcp_pkg
// Shared types for the adaptive replacement cache policy block: list codes,
// datapath operations and the command and status structs.
// ============================================================================
`default_nettype none

package arcp_pkg;

    typedef enum logic [1:0] {
        LST_T1,
        LST_T2,
        LST_B1,
        LST_B2
    } list_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_IDX_ZERO,
        OP_IDX_INC,
        OP_RD,
        OP_SHIFT_WR,
        OP_DROP_END,
        OP_SET_HIT,
        OP_P_INC,
        OP_P_DEC,
        OP_POP,
        OP_POP_RD,
        OP_PUSH_EV,
        OP_CAP_EV,
        OP_PUSH,
        OP_OUT
    } op_t;

    typedef enum logic {
        ADDR_IDX,
        ADDR_IDX_M1
    } addr_sel_t;

    typedef struct packed {
        op_t       op;
        list_t     lst;
        addr_sel_t addr_sel;
        logic      from_b2;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic idx_end;
        logic idx_zero;
        logic take_t1;
        logic t1_empty;
        logic t1b1_full;
        logic t1_full;
        logic all_ge_cap;
        logic all_ge_2cap;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/arcp_ram.sv @@
// ============================================================================
// arcp_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module arcp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/arcp_ctrl.sv @@
// ============================================================================
// arcp_ctrl
// Sequencer for one page request: list search, entry removal, replacement,
// insertion and result hand-off.
// ============================================================================
`default_nettype none

module arcp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output arcp_pkg::cmd_t        cmd,
    input  wire arcp_pkg::status_t st
);

    import arcp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DROP_RD,
        S_DROP_WR,
        S_AFTER,
        S_REP,
        S_REP_GH,
        S_MISS,
        S_MISS_EV,
        S_PUSH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    list_t  lst_reg, lst_next;
    list_t  hit_lst_reg, hit_lst_next;
    list_t  dest_reg, dest_next;
    logic   fb2_reg, fb2_next;

    always_comb
    begin
        state_next   = state_reg;
        lst_next     = lst_reg;
        hit_lst_next = hit_lst_reg;
        dest_next    = dest_reg;
        fb2_next     = fb2_reg;
        cmd.op       = OP_NONE;
        cmd.lst      = lst_reg;
        cmd.addr_sel = ADDR_IDX;
        cmd.from_b2  = fb2_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    lst_next   = LST_T1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (st.idx_end)
                begin
                    if (lst_reg == LST_B2)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        cmd.op   = OP_IDX_ZERO;
                        lst_next = list_t'(2'(lst_reg + 2'd1));
                    end
                end
                else
                begin
                    cmd.op     = OP_RD;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (st.match)
                begin
                    hit_lst_next = lst_reg;
                    state_next   = S_DROP_RD;
                    case (lst_reg)
                        LST_B1:  cmd.op = OP_P_INC;
                        LST_B2:  cmd.op = OP_P_DEC;
                        default: cmd.op = OP_SET_HIT;
                    endcase
                end
                else
                begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_RD;
                end
            end
            S_DROP_RD:
            begin
                cmd.lst = hit_lst_reg;
                if (st.idx_zero)
                begin
                    cmd.op     = OP_DROP_END;
                    state_next = S_AFTER;
                end
                else
                begin
                    cmd.op       = OP_RD;
                    cmd.addr_sel = ADDR_IDX_M1;
                    state_next   = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                cmd.lst    = hit_lst_reg;
                cmd.op     = OP_SHIFT_WR;
                state_next = S_DROP_RD;
            end
            S_AFTER:
            begin
                dest_next = LST_T2;
                if (hit_lst_reg == LST_T1 || hit_lst_reg == LST_T2)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    fb2_next   = (hit_lst_reg == LST_B2);
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                if (st.take_t1)
                begin
                    if (st.t1_empty)
                    begin
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        cmd.lst    = LST_T1;
                        cmd.op     = OP_POP_RD;
                        lst_next   = LST_B1;
                        state_next = S_REP_GH;
                    end
                end
                else
                begin
                    cmd.lst    = LST_T2;
                    cmd.op     = OP_POP_RD;
                    lst_next   = LST_B2;
                    state_next = S_REP_GH;
                end
            end
            S_REP_GH:
            begin
                cmd.op     = OP_PUSH_EV;
                state_next = S_PUSH;
            end
            S_MISS:
            begin
                dest_next = LST_T1;
                fb2_next  = 1'b0;
                if (st.t1b1_full)
                begin
                    if (!st.t1_full)
                    begin
                        cmd.lst    = LST_B1;
                        cmd.op     = OP_POP;
                        state_next = S_REP;
                    end
                    else
                    begin
                        cmd.lst    = LST_T1;
                        cmd.op     = OP_POP_RD;
                        state_next = S_MISS_EV;
                    end
                end
                else if (st.all_ge_cap)
                begin
                    if (st.all_ge_2cap)
                    begin
                        cmd.lst = LST_B2;
                        cmd.op  = OP_POP;
                    end
                    state_next = S_REP;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_MISS_EV:
            begin
                cmd.op     = OP_CAP_EV;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.lst    = dest_reg;
                cmd.op     = OP_PUSH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lst_reg     <= LST_T1;
            hit_lst_reg <= LST_T1;
            dest_reg    <= LST_T1;
            fb2_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lst_reg     <= lst_next;
            hit_lst_reg <= hit_lst_next;
            dest_reg    <= dest_next;
            fb2_reg     <= fb2_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/arcp_dp.sv @@
// ============================================================================
// arcp_dp
// Datapath: list storage as circular buffers in one RAM, list heads and
// counts, adaptive target, request and result registers.
// ============================================================================
`default_nettype none

module arcp_dp #(
    parameter int CACHE_CAPACITY = 8,
    parameter int PAGE_BITS      = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire arcp_pkg::cmd_t    cmd,
    output arcp_pkg::status_t      st,
    input  wire logic [31:0]       page_id,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic                   hit,
    output logic                   evicted_valid,
    output logic [31:0]            evicted_page
);

    import arcp_pkg::*;

    localparam int IW    = (CACHE_CAPACITY > 1) ? $clog2(CACHE_CAPACITY) : 1;
    localparam int CNTW  = $clog2(CACHE_CAPACITY + 1);
    localparam int AW    = IW + 2;
    localparam int DEPTH = 4 << IW;
    localparam int ALLW  = CNTW + 2;
    localparam logic [CNTW-1:0] CAP_N    = CNTW'(CACHE_CAPACITY);
    localparam logic [CNTW:0]   CAP_W    = (CNTW + 1)'(CACHE_CAPACITY);
    localparam logic [IW-1:0]   HEAD_MAX = IW'(CACHE_CAPACITY - 1);
    localparam logic [ALLW-1:0] ALL_CAP  = ALLW'(CACHE_CAPACITY);
    localparam logic [ALLW-1:0] ALL_2CAP = ALLW'(2 * CACHE_CAPACITY);

    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [PAGE_BITS-1:0] ev_reg, ev_next;
    logic                 hit_reg, hit_next;
    logic                 evd_reg, evd_next;
    logic [CNTW-1:0]      idx_reg, idx_next;
    logic [CNTW-1:0]      p_reg, p_next;
    logic [IW-1:0]        head_reg [4];
    logic [IW-1:0]        head_next [4];
    logic [CNTW-1:0]      cnt_reg [4];
    logic [CNTW-1:0]      cnt_next [4];
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_evd_reg, out_evd_next;
    logic [31:0]          out_page_reg, out_page_next;

    logic [63:0]          page_wide;
    logic [63:0]          ev_wide;
    logic [PAGE_BITS-1:0] q;
    logic [PAGE_BITS-1:0] wdata;
    logic [AW-1:0]        addr;
    logic                 we;
    logic                 re;
    logic [IW-1:0]        cur_head;
    logic [CNTW-1:0]      cur_cnt;
    logic [IW-1:0]        head_dec;
    logic [IW-1:0]        head_inc;
    logic [CNTW-1:0]      off;
    logic [CNTW:0]        sum;
    logic [IW-1:0]        phys;
    logic [ALLW-1:0]      all_cnt;
    logic [CNTW:0]        t1b1;

    assign page_wide = 64'(page_id);

    always_comb
    begin
        ev_wide = '0;
        ev_wide[PAGE_BITS-1:0] = ev_reg;
    end

    assign cur_head = head_reg[cmd.lst];
    assign cur_cnt  = cnt_reg[cmd.lst];
    assign head_dec = (cur_head == '0) ? HEAD_MAX : IW'(cur_head - 1'b1);
    assign head_inc = (cur_head == HEAD_MAX) ? '0 : IW'(cur_head + 1'b1);

    // logical position to physical slot
    always_comb
    begin
        case (cmd.op)
            OP_POP_RD:   off = CNTW'(cur_cnt - 1'b1);
            OP_RD:       off = (cmd.addr_sel == ADDR_IDX_M1) ? CNTW'(idx_reg - 1'b1) : idx_reg;
            default:     off = idx_reg;
        endcase
        sum = (CNTW + 1)'(cur_head) + (CNTW + 1)'(off);
        if (sum >= CAP_W)
        begin
            sum = (CNTW + 1)'(sum - CAP_W);
        end
        if (cmd.op == OP_PUSH || cmd.op == OP_PUSH_EV)
        begin
            phys = head_dec;
        end
        else
        begin
            phys = sum[IW-1:0];
        end
    end

    assign addr  = {cmd.lst, phys};
    assign re    = (cmd.op == OP_RD) || (cmd.op == OP_POP_RD);
    assign we    = (cmd.op == OP_SHIFT_WR) || (cmd.op == OP_PUSH) || (cmd.op == OP_PUSH_EV);
    assign wdata = (cmd.op == OP_PUSH) ? pg_reg : q;

    arcp_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .re    (re),
        .addr  (addr),
        .wdata (wdata),
        .rdata (q)
    );

    assign all_cnt = ALLW'(cnt_reg[LST_T1]) + ALLW'(cnt_reg[LST_T2])
                   + ALLW'(cnt_reg[LST_B1]) + ALLW'(cnt_reg[LST_B2]);
    assign t1b1    = (CNTW + 1)'(cnt_reg[LST_T1]) + (CNTW + 1)'(cnt_reg[LST_B1]);

    always_comb
    begin
        st.match       = (q == pg_reg);
        st.idx_end     = (idx_reg == cur_cnt);
        st.idx_zero    = (idx_reg == '0);
        st.take_t1     = ((cnt_reg[LST_T1] != '0) &&
                          ((cnt_reg[LST_T1] > p_reg) ||
                           (cmd.from_b2 && (cnt_reg[LST_T1] == p_reg)))) ||
                         (cnt_reg[LST_T2] == '0);
        st.t1_empty    = (cnt_reg[LST_T1] == '0);
        st.t1b1_full   = (t1b1 == CAP_W);
        st.t1_full     = (cnt_reg[LST_T1] == CAP_N);
        st.all_ge_cap  = (all_cnt >= ALL_CAP);
        st.all_ge_2cap = (all_cnt >= ALL_2CAP);
        st.out_free    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        pg_next        = pg_reg;
        ev_next        = ev_reg;
        hit_next       = hit_reg;
        evd_next       = evd_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        out_hit_next   = out_hit_reg;
        out_evd_next   = out_evd_reg;
        out_page_next  = out_page_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        case (cmd.op)
            OP_LOAD:
            begin
                pg_next  = page_wide[PAGE_BITS-1:0];
                ev_next  = '0;
                hit_next = 1'b0;
                evd_next = 1'b0;
                idx_next = '0;
            end
            OP_IDX_ZERO:
            begin
                idx_next = '0;
            end
            OP_IDX_INC:
            begin
                idx_next = CNTW'(idx_reg + 1'b1);
            end
            OP_SHIFT_WR:
            begin
                idx_next = CNTW'(idx_reg - 1'b1);
            end
            OP_DROP_END:
            begin
                head_next[cmd.lst] = head_inc;
                cnt_next[cmd.lst]  = CNTW'(cur_cnt - 1'b1);
            end
            OP_SET_HIT:
            begin
                hit_next = 1'b1;
            end
            OP_P_INC:
            begin
                if (p_reg != CAP_N)
                begin
                    p_next = CNTW'(p_reg + 1'b1);
                end
            end
            OP_P_DEC:
            begin
                if (p_reg != '0)
                begin
                    p_next = CNTW'(p_reg - 1'b1);
                end
            end
            OP_POP, OP_POP_RD:
            begin
                if (cur_cnt != '0)
                begin
                    cnt_next[cmd.lst] = CNTW'(cur_cnt - 1'b1);
                end
            end
            OP_PUSH_EV:
            begin
                head_next[cmd.lst] = head_dec;
                cnt_next[cmd.lst]  = (cur_cnt == CAP_N) ? CAP_N : CNTW'(cur_cnt + 1'b1);
                ev_next            = q;
                evd_next           = 1'b1;
            end
            OP_CAP_EV:
            begin
                ev_next  = q;
                evd_next = 1'b1;
            end
            OP_PUSH:
            begin
                head_next[cmd.lst] = head_dec;
                cnt_next[cmd.lst]  = (cur_cnt == CAP_N) ? CAP_N : CNTW'(cur_cnt + 1'b1);
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_hit_next   = hit_reg;
                out_evd_next   = evd_reg;
                out_page_next  = ev_wide[31:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            p_reg         <= CNTW'(1);
            head_reg      <= '{default: '0};
            cnt_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            p_reg         <= p_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pg_reg       <= pg_next;
        ev_reg       <= ev_next;
        hit_reg      <= hit_next;
        evd_reg      <= evd_next;
        out_hit_reg  <= out_hit_next;
        out_evd_reg  <= out_evd_next;
        out_page_reg <= out_page_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign evicted_valid = out_evd_reg;
    assign evicted_page  = out_page_reg;

endmodule

`default_nettype wire

@@ hdl/adaptive_replacement_cache_policy_top.sv @@
// ============================================================================
// adaptive_replacement_cache_policy_top
// ARC replacement policy over page numbers: resident recent and frequent
// lists, their ghost lists and an adaptive target, one result per request.
// ============================================================================
// request time is set by the entry-by-entry list search and shifting through
// one single-port RAM
// throughput: one request at a time; the next request is taken while a
// finished result still waits in the output register
// reset: lists empty, target 1, no result pending; list storage is not cleared
`default_nettype none

module adaptive_replacement_cache_policy_top #(
    parameter int CACHE_CAPACITY = 8,
    parameter int PAGE_BITS      = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] page_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic             evicted_valid,
    output logic [31:0]      evicted_page
);

    import arcp_pkg::*;

    cmd_t    cmd;
    status_t st;

    arcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .st       (st)
    );

    arcp_dp #(
        .CACHE_CAPACITY (CACHE_CAPACITY),
        .PAGE_BITS      (PAGE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .page_id       (page_id),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .hit           (hit),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page)
    );

endmodule

`default_nettype wire

@@ test/adaptive_replacement_cache_policy_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// adaptive_replacement_cache_policy_top_tb
// Drives page accesses with random gaps and stalls. Each result is checked
// against an in-bench ARC model of the four lists and the adaptive target.
// The run starts with a table of directed accesses, then random traffic.
// ============================================================================
`default_nettype none

module adaptive_replacement_cache_policy_top_tb;

    localparam int CAP        = 8;
    localparam int WATCHDOG   = 20000;
    localparam int N_DIRECTED = 22;
    localparam int N_RANDOM   = 2000;

    typedef struct packed {
        logic        hit;
        logic        ev_valid;
        logic [31:0] ev_page;
    } outcome_t;

    typedef struct {
        logic [31:0] page;
        logic        known;
        outcome_t    want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] page_id;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic        evicted_valid;
    logic [31:0] evicted_page;

    logic [31:0] t1_q[$];
    logic [31:0] t2_q[$];
    logic [31:0] b1_q[$];
    logic [31:0] b2_q[$];
    int          target_p;

    outcome_t    pending_q[$];
    outcome_t    typed_q[$];
    logic        typed_known_q[$];
    int          errors;
    int          idle_cycles;
    bit          stim_done;
    bit          hold_long;
    row_t        table_rows[N_DIRECTED];

    adaptive_replacement_cache_policy_top #(
        .CACHE_CAPACITY(CAP),
        .PAGE_BITS(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .page_id(page_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .evicted_valid(evicted_valid),
        .evicted_page(evicted_page)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_page(ref logic [31:0] q[$], input logic [31:0] pg);
        for (int i = 0; i < q.size(); i++)
        begin
            if (q[i] == pg)
                return i;
        end
        return -1;
    endfunction

    function automatic void push_front(ref logic [31:0] q[$], input logic [31:0] pg);
        if (q.size() >= CAP)
            void'(q.pop_back());
        q.push_front(pg);
    endfunction

    function automatic void arc_replace(input bit from_b2, output bit evd,
                                        output logic [31:0] ev);
        bit take_t1;
        take_t1 = t1_q.size() >= 1 && (t1_q.size() > target_p ||
                  (from_b2 && t1_q.size() == target_p));
        if (t2_q.size() == 0)
            take_t1 = 1'b1;
        evd = 1'b0;
        ev  = '0;
        if (take_t1)
        begin
            if (t1_q.size() > 0)
            begin
                ev  = t1_q.pop_back();
                evd = 1'b1;
                push_front(b1_q, ev);
            end
        end
        else if (t2_q.size() > 0)
        begin
            ev  = t2_q.pop_back();
            evd = 1'b1;
            push_front(b2_q, ev);
        end
    endfunction

    function automatic outcome_t arc_access(logic [31:0] pg);
        outcome_t    r;
        int          k;
        int          total;
        bit          evd;
        logic [31:0] ev;
        evd = 1'b0;
        ev  = '0;
        r   = '0;
        if ((k = find_page(t1_q, pg)) >= 0)
        begin
            r.hit = 1'b1;
            t1_q.delete(k);
            push_front(t2_q, pg);
        end
        else if ((k = find_page(t2_q, pg)) >= 0)
        begin
            r.hit = 1'b1;
            t2_q.delete(k);
            push_front(t2_q, pg);
        end
        else if ((k = find_page(b1_q, pg)) >= 0)
        begin
            if (target_p < CAP)
                target_p++;
            b1_q.delete(k);
            arc_replace(1'b0, evd, ev);
            push_front(t2_q, pg);
        end
        else if ((k = find_page(b2_q, pg)) >= 0)
        begin
            if (target_p > 0)
                target_p--;
            b2_q.delete(k);
            arc_replace(1'b1, evd, ev);
            push_front(t2_q, pg);
        end
        else
        begin
            total = t1_q.size() + t2_q.size() + b1_q.size() + b2_q.size();
            if (t1_q.size() + b1_q.size() == CAP)
            begin
                if (t1_q.size() < CAP)
                begin
                    void'(b1_q.pop_back());
                    arc_replace(1'b0, evd, ev);
                end
                else
                begin
                    ev  = t1_q.pop_back();
                    evd = 1'b1;
                end
            end
            else if (total >= CAP)
            begin
                if (total >= 2 * CAP && b2_q.size() > 0)
                    void'(b2_q.pop_back());
                arc_replace(1'b0, evd, ev);
            end
            push_front(t1_q, pg);
        end
        r.ev_valid = evd;
        r.ev_page  = evd ? ev : '0;
        return r;
    endfunction

    function automatic row_t mk(logic [31:0] pg, logic known, outcome_t want);
        row_t r;
        r.page  = pg;
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    // directed table: cold misses, extremes, hits, ghost hits, fill and evictions
    initial
    begin
        table_rows[0]  = mk(32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0});
        table_rows[1]  = mk(32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0});
        table_rows[2]  = mk(32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0});
        table_rows[3]  = mk(32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0});
        table_rows[4]  = mk(32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0});
        for (int i = 5; i < 13; i++)
            table_rows[i] = mk(32'h100 + i, 1'b0, '0);
        table_rows[13] = mk(32'h106, 1'b0, '0);
        table_rows[14] = mk(32'h0000_0000, 1'b0, '0);
        table_rows[15] = mk(32'hFFFF_FFFF, 1'b0, '0);
        table_rows[16] = mk(32'h105, 1'b0, '0);
        table_rows[17] = mk(32'hAAAA_AAAA, 1'b0, '0);
        table_rows[18] = mk(32'h5555_5555, 1'b0, '0);
        table_rows[19] = mk(32'h107, 1'b0, '0);
        table_rows[20] = mk(32'h108, 1'b0, '0);
        table_rows[21] = mk(32'h8000_0001, 1'b0, '0);
    end

    function automatic logic [31:0] rand_page();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            return 32'h200 + $urandom_range(0, 23);
        else if (sel == 8)
            return $urandom;
        else
            return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(0, 3))};
    endfunction

    task automatic send(logic [31:0] pg, logic known, outcome_t want);
        int gap;
        gap = hold_long ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        page_id  <= pg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_q.push_back(arc_access(pg));
        typed_q.push_back(want);
        typed_known_q.push_back(known);
    endtask

    initial
    begin
        in_valid  = 1'b0;
        page_id   = '0;
        rst_n     = 1'b0;
        errors    = 0;
        stim_done = 1'b0;
        hold_long = 1'b0;
        target_p  = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send(table_rows[i].page, table_rows[i].known, table_rows[i].want);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
                hold_long = 1'b1;
            if (i == 340)
                hold_long = 1'b0;
            send(rand_page(), 1'b0, '0);
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stalls, with one long hold-off while requests keep coming
    initial
    begin
        int wait_n;
        bit held;
        held      = 1'b0;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_long && !held)
            begin
                wait_n = 400;
                held   = 1'b1;
            end
            else
            begin
                wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
            end
            if (wait_n != 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            outcome_t got;
            outcome_t exp_o;
            got = '{hit, evicted_valid, evicted_page};
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b ev=%0b page=%h",
                         $time, hit, evicted_valid, evicted_page);
                errors++;
            end
            else
            begin
                exp_o = pending_q.pop_front();
                if (typed_known_q.pop_front() && typed_q[0] != exp_o)
                begin
                    $display("%0t: table row disagrees with model", $time);
                    errors++;
                end
                void'(typed_q.pop_front());
                if (got.hit !== exp_o.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, exp_o.hit, got.hit);
                    errors++;
                end
                if (got.ev_valid !== exp_o.ev_valid)
                begin
                    $display("%0t: evicted_valid expected %0b actual %0b",
                             $time, exp_o.ev_valid, got.ev_valid);
                    errors++;
                end
                if (got.ev_page !== exp_o.ev_page)
                begin
                    $display("%0t: evicted_page expected %h actual %h",
                             $time, exp_o.ev_page, got.ev_page);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            if (stim_done && pending_q.size() == 0)
            begin
                repeat (10 * CAP + 20) @(posedge clk);
                if (errors == 0 && pending_q.size() == 0)
                    $display("DONE: 0 errors");
                else
                    $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/arcp_pkg.sv
hdl/arcp_ram.sv
hdl/arcp_ctrl.sv
hdl/arcp_dp.sv
hdl/adaptive_replacement_cache_policy_top.sv
test/adaptive_replacement_cache_policy_top_tb.sv
